>>> rtl/core/audio_gain_with_level_meter_unit_defines.svh
`ifndef AUDIO_GAIN_WITH_LEVEL_METER_UNIT_DEFINES_SVH
`define AUDIO_GAIN_WITH_LEVEL_METER_UNIT_DEFINES_SVH

// Checks on clk, quiet while rst_n is low. Both expect clk and rst_n in scope.
`define AGLM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define AGLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/aglm_pkg.sv
`timescale 1ns / 1ps

package aglm_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int SUM_W           = 41;
  localparam int CNT_W           = 11;
  localparam int BLOCK_SAMPLES   = 1024;
  localparam int OUTPUT_CHANNELS = 2;

  // sum * 36 fits in 46 bits; its floor root fits in 23
  localparam int NUM_W      = 46;
  localparam int ROOT_W     = 23;
  localparam int SREM_W     = 25;
  localparam int DREM_W     = 11;
  localparam int DIV_STEPS  = 46;
  localparam int SQRT_STEPS = 23;
  localparam int ITER_W     = 6;

  // x / 10 == (x * 838861) >> 23 for x < 2^22
  localparam int MIX_W       = 20;
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 23;
  localparam logic [RECIP_W-1:0] RECIP_10 = 24'd838861;

  localparam logic [15:0] GAIN_RESET = 16'd32768;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic CFG_IDX_GAIN = 1'b0;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_present;
    logic                       end_of_block;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic [15:0]                level;
    logic                       level_updated;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SAT,
    ST_SQR,
    ST_ACC,
    ST_CHK,
    ST_DIV_LOAD,
    ST_DIV,
    ST_SQRT_LOAD,
    ST_SQRT,
    ST_MIX,
    ST_LEVEL,
    ST_OUT
  } aglm_state_t;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic sat;
    logic sqr;
    logic acc;
    logic clr_blk;
    logic div_load;
    logic div_step;
    logic sq_load;
    logic sq_step;
    logic mix;
    logic level;
    logic out_load;
  } aglm_cmd_t;

  typedef struct packed {
    logic eob;
    logic cnt_nz;
  } aglm_sts_t;

endpackage

>>> rtl/core/aglm_dp.sv
`timescale 1ns / 1ps

module aglm_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  aglm_pkg::aglm_cmd_t cmd,
  input  aglm_pkg::in_item_t  in_data,
  input  logic [15:0]         volume_gain,
  output aglm_pkg::aglm_sts_t sts,
  output aglm_pkg::out_item_t out_data
);

  aglm_pkg::in_item_t in_r;
  aglm_pkg::out_item_t out_r;

  logic signed [32:0] prod_r;
  logic signed [aglm_pkg::SAMPLE_W-1:0] y_r;
  logic [30:0] sq_r;
  logic [aglm_pkg::SUM_W-1:0] sum_r;
  logic [aglm_pkg::CNT_W-1:0] cnt_r;
  logic [aglm_pkg::NUM_W-1:0] num_r;
  logic [aglm_pkg::DREM_W-1:0] drem_r;
  logic [aglm_pkg::SREM_W-1:0] srem_r;
  logic [aglm_pkg::ROOT_W-1:0] root_r;
  logic [aglm_pkg::MIX_W-1:0] mix_r;
  logic [15:0] level_r;
  logic upd_r;

  logic signed [32:0] prod_nxt;
  logic signed [32:0] biased;
  logic signed [17:0] quo;
  logic signed [aglm_pkg::SAMPLE_W-1:0] y_nxt;
  logic signed [31:0] sq_full;
  logic counting;
  logic [aglm_pkg::NUM_W-1:0] mul36;
  logic [aglm_pkg::DREM_W:0] dshift;
  logic [aglm_pkg::DREM_W:0] ddiff;
  logic dge;
  logic [aglm_pkg::DREM_W-1:0] drem_nxt;
  logic [aglm_pkg::SREM_W+1:0] st;
  logic [aglm_pkg::SREM_W+1:0] trial;
  logic [aglm_pkg::SREM_W+1:0] sdiff;
  logic sge;
  logic [15:0] nv;
  logic [aglm_pkg::MIX_W-1:0] mix_nxt;
  logic [aglm_pkg::MIX_W+aglm_pkg::RECIP_W-1:0] rprod;
  logic [aglm_pkg::MIX_W+aglm_pkg::RECIP_W-aglm_pkg::RECIP_SHIFT-1:0] lv_q;
  logic [15:0] lv_nxt;

  // gain is unsigned, so widen with a zero sign bit
  assign prod_nxt = 33'(in_r.sample) * 33'($signed({1'b0, volume_gain}));

  // divide by 2^15 rounding toward zero, then saturate
  assign biased = prod_r + (prod_r[32] ? 33'sd32767 : 33'sd0);
  assign quo    = biased[32:15];

  always_comb begin
    if (!quo[17] && (quo[16:15] != 2'b00)) begin
      y_nxt = 16'sh7FFF;
    end else if (quo[17] && (quo[16:15] != 2'b11)) begin
      y_nxt = 16'sh8000;
    end else begin
      y_nxt = quo[15:0];
    end
  end

  assign sq_full  = y_r * y_r;
  assign counting = in_r.sample_present &&
                    (cnt_r < aglm_pkg::CNT_W'(aglm_pkg::BLOCK_SAMPLES));
  assign mul36    = (aglm_pkg::NUM_W'(sum_r) << 5) + (aglm_pkg::NUM_W'(sum_r) << 2);

  // restoring divide by the sample count, one quotient bit per step
  assign dshift   = {drem_r, num_r[aglm_pkg::NUM_W-1]};
  assign dge      = dshift >= {1'b0, cnt_r};
  assign ddiff    = dshift - {1'b0, cnt_r};
  assign drem_nxt = dge ? ddiff[aglm_pkg::DREM_W-1:0] : dshift[aglm_pkg::DREM_W-1:0];

  // digit-by-digit root, two radicand bits per step
  assign st    = {srem_r, num_r[aglm_pkg::NUM_W-1 -: 2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign sge   = st >= trial;
  assign sdiff = st - trial;

  assign nv = (root_r[aglm_pkg::ROOT_W-1:16] != '0) ? 16'hFFFF : root_r[15:0];

  assign mix_nxt = (aglm_pkg::MIX_W'(level_r) << 3) - aglm_pkg::MIX_W'(level_r) +
                   (aglm_pkg::MIX_W'(nv) << 1) + aglm_pkg::MIX_W'(nv) +
                   aglm_pkg::MIX_W'(5);

  assign rprod  = (aglm_pkg::MIX_W+aglm_pkg::RECIP_W)'(mix_r) *
                  (aglm_pkg::MIX_W+aglm_pkg::RECIP_W)'(aglm_pkg::RECIP_10);
  assign lv_q   = rprod[aglm_pkg::MIX_W+aglm_pkg::RECIP_W-1:aglm_pkg::RECIP_SHIFT];
  assign lv_nxt = (lv_q[$bits(lv_q)-1:16] != '0) ? 16'hFFFF : lv_q[15:0];

  // block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      cnt_r   <= '0;
      level_r <= '0;
      upd_r   <= 1'b0;
    end else begin
      if (cmd.clr_blk) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else if (cmd.acc && counting) begin
        sum_r <= sum_r + aglm_pkg::SUM_W'(sq_r);
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.level) begin
        level_r <= lv_nxt;
      end
      if (cmd.load_in) begin
        upd_r <= 1'b0;
      end else if (cmd.level) begin
        upd_r <= 1'b1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.sat) begin
      y_r <= in_r.sample_present ? y_nxt : '0;
    end
    if (cmd.sqr) begin
      sq_r <= sq_full[30:0];
    end
    if (cmd.div_load) begin
      num_r <= mul36;
    end else if (cmd.div_step) begin
      num_r <= {num_r[aglm_pkg::NUM_W-2:0], dge};
    end else if (cmd.sq_step) begin
      num_r <= {num_r[aglm_pkg::NUM_W-3:0], 2'b00};
    end
    if (cmd.div_load) begin
      drem_r <= '0;
    end else if (cmd.div_step) begin
      drem_r <= drem_nxt;
    end
    if (cmd.sq_load) begin
      srem_r <= '0;
      root_r <= '0;
    end else if (cmd.sq_step) begin
      srem_r <= sge ? sdiff[aglm_pkg::SREM_W-1:0] : st[aglm_pkg::SREM_W-1:0];
      root_r <= {root_r[aglm_pkg::ROOT_W-2:0], sge};
    end
    if (cmd.mix) begin
      mix_r <= mix_nxt;
    end
    if (cmd.out_load) begin
      out_r.left_sample   <= y_r;
      out_r.right_sample  <= (aglm_pkg::OUTPUT_CHANNELS >= 2) ? y_r : '0;
      out_r.level         <= level_r;
      out_r.level_updated <= upd_r;
    end
  end

  assign sts.eob    = in_r.end_of_block;
  assign sts.cnt_nz = cnt_r != '0;
  assign out_data   = out_r;

endmodule

>>> rtl/core/aglm_ctrl.sv
`timescale 1ns / 1ps
`include "audio_gain_with_level_meter_unit_defines.svh"

module aglm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  aglm_pkg::aglm_sts_t sts,
  output aglm_pkg::aglm_cmd_t cmd
);

  aglm_pkg::aglm_state_t state_r, state_nxt;
  logic [aglm_pkg::ITER_W-1:0] iter_r, iter_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  // output register frees up in the same cycle its item is taken
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aglm_pkg::ST_IDLE:      if (in_valid) state_nxt = aglm_pkg::ST_MUL;
      aglm_pkg::ST_MUL:       state_nxt = aglm_pkg::ST_SAT;
      aglm_pkg::ST_SAT:       state_nxt = aglm_pkg::ST_SQR;
      aglm_pkg::ST_SQR:       state_nxt = aglm_pkg::ST_ACC;
      aglm_pkg::ST_ACC:       state_nxt = aglm_pkg::ST_CHK;
      aglm_pkg::ST_CHK: begin
        if (sts.eob && sts.cnt_nz) begin
          state_nxt = aglm_pkg::ST_DIV_LOAD;
        end else begin
          state_nxt = aglm_pkg::ST_OUT;
        end
      end
      aglm_pkg::ST_DIV_LOAD:  state_nxt = aglm_pkg::ST_DIV;
      aglm_pkg::ST_DIV: begin
        if (iter_r == aglm_pkg::ITER_W'(aglm_pkg::DIV_STEPS - 1)) begin
          state_nxt = aglm_pkg::ST_SQRT_LOAD;
        end
      end
      aglm_pkg::ST_SQRT_LOAD: state_nxt = aglm_pkg::ST_SQRT;
      aglm_pkg::ST_SQRT: begin
        if (iter_r == aglm_pkg::ITER_W'(aglm_pkg::SQRT_STEPS - 1)) begin
          state_nxt = aglm_pkg::ST_MIX;
        end
      end
      aglm_pkg::ST_MIX:       state_nxt = aglm_pkg::ST_LEVEL;
      aglm_pkg::ST_LEVEL:     state_nxt = aglm_pkg::ST_OUT;
      aglm_pkg::ST_OUT:       if (out_free) state_nxt = aglm_pkg::ST_IDLE;
      default:                state_nxt = aglm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if ((state_r == aglm_pkg::ST_DIV) || (state_r == aglm_pkg::ST_SQRT)) begin
      iter_nxt = iter_r + 1'b1;
    end else begin
      iter_nxt = '0;
    end
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      aglm_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      aglm_pkg::ST_MUL:       cmd.mul = 1'b1;
      aglm_pkg::ST_SAT:       cmd.sat = 1'b1;
      aglm_pkg::ST_SQR:       cmd.sqr = 1'b1;
      aglm_pkg::ST_ACC:       cmd.acc = 1'b1;
      // empty block end: drop the sums, level stays
      aglm_pkg::ST_CHK:       cmd.clr_blk = sts.eob && !sts.cnt_nz;
      aglm_pkg::ST_DIV_LOAD:  cmd.div_load = 1'b1;
      aglm_pkg::ST_DIV:       cmd.div_step = 1'b1;
      aglm_pkg::ST_SQRT_LOAD: cmd.sq_load = 1'b1;
      aglm_pkg::ST_SQRT:      cmd.sq_step = 1'b1;
      aglm_pkg::ST_MIX:       cmd.mix = 1'b1;
      aglm_pkg::ST_LEVEL: begin
        cmd.level   = 1'b1;
        cmd.clr_blk = 1'b1;
      end
      aglm_pkg::ST_OUT:       cmd.out_load = out_free;
      default:                cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aglm_pkg::ST_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `AGLM_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_r == aglm_pkg::ST_MUL, "accepted item did not start")
  `AGLM_ASSERT_SAME(a_div_bound, state_r == aglm_pkg::ST_DIV, iter_r < aglm_pkg::ITER_W'(aglm_pkg::DIV_STEPS), "divide ran past its steps")
  `AGLM_ASSERT_SAME(a_mix_counted, state_r == aglm_pkg::ST_MIX, sts.cnt_nz, "level update with empty block")
  `AGLM_ASSERT_NEXT(a_out_held, state_r == aglm_pkg::ST_OUT && out_valid_r && out_stall, state_r == aglm_pkg::ST_OUT && out_valid_r, "result dropped while output busy")

endmodule

>>> rtl/core/audio_gain_with_level_meter_unit.sv
`timescale 1ns / 1ps

// Volume scaler with RMS level meter. Each item is one signed 16-bit sample; it is
// scaled by the Q1.15 volume_gain (APB byte address 0, reset 32768 = unity),
// rounded toward zero, saturated and returned on both channels with the current
// level. Padding items return zero and are not counted. An ordinary item goes
// through multiply, saturate, square, accumulate and check before its result is
// loaded into the output register. For an item that ends a block holding counted
// samples, the mean-square divide then runs one quotient bit per cycle and the
// square root one root bit per cycle, followed by the smoothing step. The output
// register lets the next item be accepted while a result still waits to be taken.
module audio_gain_with_level_meter_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  aglm_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output aglm_pkg::out_item_t                  out_data,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [aglm_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [aglm_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [aglm_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  aglm_pkg::aglm_cmd_t cmd;
  aglm_pkg::aglm_sts_t sts;
  logic [15:0] gain_r;
  logic cfg_wr;
  logic cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[aglm_pkg::CFG_ADDR_W-1];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= aglm_pkg::GAIN_RESET;
    end else if (cfg_wr && (cfg_idx == aglm_pkg::CFG_IDX_GAIN)) begin
      gain_r <= pwdata[15:0];
    end
  end

  always_comb begin
    if (cfg_idx == aglm_pkg::CFG_IDX_GAIN) begin
      prdata = aglm_pkg::CFG_DATA_W'(gain_r);
    end else begin
      prdata = '0;
    end
  end

  aglm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  aglm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_data     (in_data),
    .volume_gain (gain_r),
    .sts         (sts),
    .out_data    (out_data)
  );

endmodule
